@@ rtl/q_table_learning_engine_macros.svh @@
// assertion macros used by q_table_learning_engine.sv
`ifndef Q_TABLE_LEARNING_ENGINE_MACROS_SVH
`define Q_TABLE_LEARNING_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define QTLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qtle assertion failed");

// next-cycle implication
`define QTLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qtle assertion failed");

`else

`define QTLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define QTLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/qtle_pkg.sv @@
`default_nettype none

package qtle_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_ACTIONS = 8;
    localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;

    // fixed field widths
    localparam int STATE_W = 6;
    localparam int ACTION_W = 3;
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;

    localparam int ROW_W  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int COL_W  = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);

    // register indexes
    localparam logic REG_LEARNING_RATE   = 1'b0;
    localparam logic REG_DISCOUNT_FACTOR = 1'b1;

    // op codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_QRD,
        S_WAITQ,
        S_MUL1,
        S_TD,
        S_MUL2,
        S_WB,
        S_QLAST,
        S_KCALC,
        S_PICK,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_ROW,
        TAG_Q
    } t_rd_tag;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic [COL_W-1:0] col;
    } t_scan_ctl;

    function automatic logic [ROW_W-1:0] clamp_state(input logic [STATE_W-1:0] s);
        if (int'(s) >= NUM_STATES) begin
            return ROW_W'(NUM_STATES - 1);
        end
        return ROW_W'(s);
    endfunction

    function automatic logic [COL_W-1:0] clamp_action(input logic [ACTION_W-1:0] a);
        if (int'(a) >= NUM_ACTIONS) begin
            return COL_W'(NUM_ACTIONS - 1);
        end
        return COL_W'(a);
    endfunction

    function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(row) * ADDR_W'(NUM_ACTIONS));
        return ADDR_W'(base + ADDR_W'(col));
    endfunction

endpackage

`default_nettype wire

@@ rtl/qtle_row_scan.sv @@
`default_nettype none

// running row maximum, count of columns holding it, and their mask
module qtle_row_scan (
    input  wire                                   i_clk,
    input  wire qtle_pkg::t_scan_ctl              i_ctl,
    input  wire logic signed [qtle_pkg::VAL_W-1:0] i_data,
    output logic signed [qtle_pkg::VAL_W-1:0]      o_max,
    output logic [qtle_pkg::CNT_W-1:0]             o_cnt,
    output logic [qtle_pkg::NUM_ACTIONS-1:0]       o_mask
);

    logic signed [qtle_pkg::VAL_W-1:0] r_max, n_max;
    logic [qtle_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [qtle_pkg::NUM_ACTIONS-1:0]  r_mask, n_mask;
    logic [qtle_pkg::NUM_ACTIONS-1:0]  col_bit;

    assign col_bit = qtle_pkg::NUM_ACTIONS'(1) << i_ctl.col;

    always_comb begin
        n_max  = r_max;
        n_cnt  = r_cnt;
        n_mask = r_mask;
        if (i_ctl.vld) begin
            if (i_ctl.first || (i_data > r_max)) begin
                // first column or a new maximum restarts the tie set
                n_max  = i_data;
                n_cnt  = qtle_pkg::CNT_W'(1);
                n_mask = col_bit;
            end else if (i_data == r_max) begin
                n_cnt  = qtle_pkg::CNT_W'(r_cnt + 1'b1);
                n_mask = r_mask | col_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_max  <= n_max;
        r_cnt  <= n_cnt;
        r_mask <= n_mask;
    end

    assign o_max  = r_max;
    assign o_cnt  = r_cnt;
    assign o_mask = r_mask;

endmodule

`default_nettype wire

@@ rtl/q_table_learning_engine.sv @@
// update: scan the next state's row, read the entry, gamma product, TD, alpha product, write back with result
// query: scan its own row, derive the tie index from the tie count, walk the tie mask to it, then output
// busy: o_stall stays high from accept until the result is registered, so the next transaction
// can be taken in the same cycle that o_valid rises; one transaction is in flight at a time
// row scan reads one entry per cycle; a waiting result holds the output register meanwhile
// reset: control and config registers to defaults, then a clearing pass over every entry with o_stall high
`default_nettype none

`include "q_table_learning_engine_macros.svh"

module q_table_learning_engine (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    // config port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // input channel
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_op,
    input  wire  [5:0]          i_state_index,
    input  wire  [2:0]          i_action_index,
    input  wire  [5:0]          i_next_state_index,
    input  wire  signed [31:0]  i_reward,
    input  wire  [15:0]         i_tie_random,

    // output channel
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [2:0]          o_best_action,
    output logic signed [31:0]  o_value_out,
    output logic                o_saturated
);

    localparam int VW = qtle_pkg::VAL_W;
    localparam int CW = qtle_pkg::COL_W;
    localparam int RW = qtle_pkg::ROW_W;
    localparam int AW = qtle_pkg::ADDR_W;
    localparam int NW = qtle_pkg::CNT_W;
    localparam int FW = qtle_pkg::FRAC_W;

    localparam logic [CW-1:0] LAST_COL = CW'(qtle_pkg::NUM_ACTIONS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(qtle_pkg::DEPTH - 1);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [FW-1:0] r_lr;
    logic [FW-1:0] r_df;
    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= FW'(6554);
            r_df <= FW'(58982);
        end else if (cfg_wr) begin
            // register picked by paddr[2]; low address bits ignored
            case (paddr[2])
                qtle_pkg::REG_LEARNING_RATE:   r_lr <= pwdata[FW-1:0];
                qtle_pkg::REG_DISCOUNT_FACTOR: r_df <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            qtle_pkg::REG_LEARNING_RATE:   prdata = {16'b0, r_lr};
            qtle_pkg::REG_DISCOUNT_FACTOR: prdata = {16'b0, r_df};
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control and datapath registers
    // ------------------------------------------------------------------
    qtle_pkg::t_state  r_state, n_state;
    qtle_pkg::t_rd_tag r_rd_tag, n_rd_tag;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_out_vld, n_out_vld;

    logic                 r_op, n_op;
    logic [RW-1:0]        r_s, n_s;
    logic [CW-1:0]        r_a, n_a;
    logic [RW-1:0]        r_ns, n_ns;
    logic signed [VW-1:0] r_reward, n_reward;
    logic [FW-1:0]        r_tie, n_tie;
    logic [CW-1:0]        r_col, n_col;
    logic [CW-1:0]        r_rd_col;
    logic [NW-1:0]        r_seen, n_seen;
    logic [NW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_pick, n_pick;
    logic signed [VW-1:0] r_q, n_q;
    logic signed [47:0]   r_prod1, n_prod1;
    logic signed [33:0]   r_td, n_td;
    logic signed [50:0]   r_prod2, n_prod2;
    logic [2:0]           r_out_act, n_out_act;
    logic signed [VW-1:0] r_out_val, n_out_val;
    logic                 r_out_sat, n_out_sat;

    // ------------------------------------------------------------------
    // q table: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [VW-1:0]        mem [qtle_pkg::DEPTH];
    logic signed [VW-1:0] r_rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [VW-1:0]        mem_wdata;
    logic [AW-1:0]        rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // row scan: max, tie count and tie mask of the scanned row
    // ------------------------------------------------------------------
    qtle_pkg::t_scan_ctl                  scan_ctl;
    logic signed [VW-1:0]                 scan_max;
    logic [NW-1:0]                        scan_cnt;
    logic [qtle_pkg::NUM_ACTIONS-1:0]     scan_mask;

    assign scan_ctl.vld   = (r_rd_tag == qtle_pkg::TAG_ROW);
    assign scan_ctl.first = (r_rd_col == '0);
    assign scan_ctl.col   = r_rd_col;

    qtle_row_scan u_row_scan (
        .i_clk  (i_clk),
        .i_ctl  (scan_ctl),
        .i_data (r_rd_data),
        .o_max  (scan_max),
        .o_cnt  (scan_cnt),
        .o_mask (scan_mask)
    );

    // ------------------------------------------------------------------
    // arithmetic
    // ------------------------------------------------------------------
    logic                 in_acc;
    logic                 out_acc;
    logic                 out_free;
    logic [RW-1:0]        scan_row;
    logic signed [47:0]   prod1;
    logic signed [VW-1:0] d_val;
    logic signed [50:0]   prod2;
    logic signed [34:0]   del;
    logic signed [35:0]   nv;
    logic                 sat_flag;
    logic [VW-1:0]        sat_val;
    logic [FW+NW-1:0]     kprod;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_vld && !i_stall;
    assign out_free = !r_out_vld || !i_stall;

    // a query scans its own row, an update the next state's row
    assign scan_row = (r_op == qtle_pkg::OP_QUERY) ? r_s : r_ns;

    // gamma * maxQ, gamma unsigned so widened with a zero sign bit
    assign prod1 = 48'(scan_max) * 48'($signed({1'b0, r_df}));
    // floor(product / 2^16) is the upper slice
    assign d_val = r_prod1[47:16];
    // alpha * temporal difference
    assign prod2 = 51'(r_td) * 51'($signed({1'b0, r_lr}));
    assign del   = r_prod2[50:16];
    assign nv    = 36'(r_q) + 36'(del);

    // clip when the top bits disagree with the 32-bit sign
    assign sat_flag = !((nv[35:31] == 5'b00000) || (nv[35:31] == 5'b11111));
    assign sat_val  = !sat_flag ? nv[31:0] :
                      (nv[35] ? 32'h8000_0000 : 32'h7fff_ffff);

    // tie pick index k = (tie_random * count) >> 16
    assign kprod = {{NW{1'b0}}, r_tie} * {{FW{1'b0}}, scan_cnt};

    always_comb begin
        n_state    = r_state;
        n_rd_tag   = qtle_pkg::TAG_NONE;
        n_clr_addr = r_clr_addr;
        n_op       = r_op;
        n_s        = r_s;
        n_a        = r_a;
        n_ns       = r_ns;
        n_reward   = r_reward;
        n_tie      = r_tie;
        n_col      = r_col;
        n_seen     = r_seen;
        n_k        = r_k;
        n_pick     = r_pick;
        n_q        = r_q;
        n_prod1    = r_prod1;
        n_td       = r_td;
        n_prod2    = r_prod2;
        n_out_act  = r_out_act;
        n_out_val  = r_out_val;
        n_out_sat  = r_out_sat;
        n_out_vld  = r_out_vld && !out_acc;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = '0;
        rd_addr    = qtle_pkg::row_addr(scan_row, r_col);

        // entry being updated comes back from the registered read port in the cycle after its read
        if (r_rd_tag == qtle_pkg::TAG_Q) begin
            n_q = r_rd_data;
        end

        case (r_state)
            qtle_pkg::S_CLEAR: begin
                // zero one entry per cycle after reset
                mem_we     = 1'b1;
                n_clr_addr = AW'(r_clr_addr + 1'b1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = qtle_pkg::S_IDLE;
                end
            end
            qtle_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_op;
                    n_s      = qtle_pkg::clamp_state(i_state_index);
                    n_a      = qtle_pkg::clamp_action(i_action_index);
                    n_ns     = qtle_pkg::clamp_state(i_next_state_index);
                    n_reward = i_reward;
                    n_tie    = i_tie_random;
                    n_col    = '0;
                    n_state  = qtle_pkg::S_SCAN;
                end
            end
            qtle_pkg::S_SCAN: begin
                // one column read per cycle
                n_rd_tag = qtle_pkg::TAG_ROW;
                n_col    = CW'(r_col + 1'b1);
                if (r_col == LAST_COL) begin
                    n_col   = '0;
                    n_state = (r_op == qtle_pkg::OP_QUERY) ? qtle_pkg::S_QLAST
                                                           : qtle_pkg::S_QRD;
                end
            end
            qtle_pkg::S_QRD: begin
                // row max is read before the write-back, so same-row updates are safe
                rd_addr  = qtle_pkg::row_addr(r_s, r_a);
                n_rd_tag = qtle_pkg::TAG_Q;
                n_state  = qtle_pkg::S_WAITQ;
            end
            qtle_pkg::S_WAITQ: begin
                n_state = qtle_pkg::S_MUL1;
            end
            qtle_pkg::S_MUL1: begin
                n_prod1 = prod1;
                n_state = qtle_pkg::S_TD;
            end
            qtle_pkg::S_TD: begin
                // reward + discounted max - q at full width
                n_td    = 34'(r_reward) + 34'(d_val) - 34'(r_q);
                n_state = qtle_pkg::S_MUL2;
            end
            qtle_pkg::S_MUL2: begin
                n_prod2 = prod2;
                n_state = qtle_pkg::S_WB;
            end
            qtle_pkg::S_WB: begin
                // write back together with the result, once the output slot is free
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = qtle_pkg::row_addr(r_s, r_a);
                    mem_wdata = sat_val;
                    n_out_vld = 1'b1;
                    n_out_act = '0;
                    n_out_val = sat_val;
                    n_out_sat = sat_flag;
                    n_state   = qtle_pkg::S_IDLE;
                end
            end
            qtle_pkg::S_QLAST: begin
                // last column lands in the row scan this cycle
                n_state = qtle_pkg::S_KCALC;
            end
            qtle_pkg::S_KCALC: begin
                n_k     = kprod[FW +: NW];
                n_col   = '0;
                n_seen  = '0;
                n_state = qtle_pkg::S_PICK;
            end
            qtle_pkg::S_PICK: begin
                // walk the tie mask until the k-th set bit, counted from zero
                n_col = CW'(r_col + 1'b1);
                if (scan_mask[r_col]) begin
                    if (r_seen == r_k) begin
                        n_pick  = r_col;
                        n_state = qtle_pkg::S_OUT;
                    end else begin
                        n_seen = NW'(r_seen + 1'b1);
                    end
                end
            end
            qtle_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_act = 3'(r_pick);
                    n_out_val = scan_max;
                    n_out_sat = 1'b0;
                    n_state   = qtle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qtle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= qtle_pkg::S_CLEAR;
            r_rd_tag   <= qtle_pkg::TAG_NONE;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_tag   <= n_rd_tag;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_s       <= n_s;
        r_a       <= n_a;
        r_ns      <= n_ns;
        r_reward  <= n_reward;
        r_tie     <= n_tie;
        r_col     <= n_col;
        r_rd_col  <= r_col;
        r_seen    <= n_seen;
        r_k       <= n_k;
        r_pick    <= n_pick;
        r_q       <= n_q;
        r_prod1   <= n_prod1;
        r_td      <= n_td;
        r_prod2   <= n_prod2;
        r_out_act <= n_out_act;
        r_out_val <= n_out_val;
        r_out_sat <= n_out_sat;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign o_stall       = (r_state != qtle_pkg::S_IDLE);
    assign o_valid       = r_out_vld;
    assign o_best_action = r_out_act;
    assign o_value_out   = r_out_val;
    assign o_saturated   = r_out_sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic chk_wr_ext;
    logic chk_clr_last;
    logic chk_cnt_ok;

    assign chk_wr_ext   = mem_we && (r_state != qtle_pkg::S_CLEAR);
    assign chk_clr_last = (r_state == qtle_pkg::S_CLEAR) && (r_clr_addr == LAST_ADDR);
    assign chk_cnt_ok   = (scan_cnt != '0) && (int'(scan_cnt) <= qtle_pkg::NUM_ACTIONS);

    // accepted transaction keeps the block busy
    `QTLE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_stall)
    // table written only by the clearing pass or the update write-back
    `QTLE_ASSERT_SAME(a_write_source, i_clk, i_rst_n, chk_wr_ext, r_state == qtle_pkg::S_WB)
    // clearing pass ends after the last entry
    `QTLE_ASSERT_NEXT(a_clear_done, i_clk, i_rst_n, chk_clr_last, r_state == qtle_pkg::S_IDLE)
    // tie count of a finished scan lies in one to NUM_ACTIONS
    `QTLE_ASSERT_SAME(a_tie_count, i_clk, i_rst_n, r_state == qtle_pkg::S_KCALC, chk_cnt_ok)
    // a result never carries both an action and a clip flag
    `QTLE_ASSERT_SAME(a_result_kind, i_clk, i_rst_n, r_out_vld, !(r_out_sat && (r_out_act != 3'd0)))

endmodule

`default_nettype wire
